@@ rtl/shifting_list_engine_top_defines.svh @@
// assertion macros used by the list engine command sequencer
`ifndef SHIFTING_LIST_ENGINE_TOP_DEFINES_SVH
`define SHIFTING_LIST_ENGINE_TOP_DEFINES_SVH

// expression holds at every clock edge out of reset
`define SLE_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
// constants, codes and the slot control struct of the list engine
package sle_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W  = $clog2(SLOTS + 1);
  localparam int DATA_W = 32;
  localparam int CMD_W  = 4;
  localparam int POS_W  = 5;
  localparam int IDX_W  = 4;
  localparam int STAT_W = 3;
  localparam int OLEN_W = 5;
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_FIRST = 4'd1,
    CMD_INS_LAST  = 4'd2,
    CMD_INS_AT    = 4'd3,
    CMD_DEL_FIRST = 4'd4,
    CMD_DEL_LAST  = 4'd5,
    CMD_DEL_AT    = 4'd6,
    CMD_GET       = 4'd7,
    CMD_SET       = 4'd8,
    CMD_FIND      = 4'd9,
    CMD_STATUS    = 4'd10
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // broadcast to every slot: up takes from the lower neighbor, dn from the upper one
  typedef struct packed {
    logic              clr;
    logic              place;
    logic              kill;
    logic              up;
    logic              dn;
    logic [SLOT_W-1:0] sel;
    logic [SLOT_W-1:0] lo;
    logic [SLOT_W-1:0] hi;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/sle_cell.sv @@
// one list slot: holds an element and its valid bit, shifts with its neighbors
module sle_cell import sle_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] idx,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] lo_data,
  input  logic              lo_valid,
  input  logic [DATA_W-1:0] hi_data,
  input  logic              hi_valid,
  output logic [DATA_W-1:0] data_o,
  output logic              valid_o,
  output logic              match_o
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;
  logic              match_r;
  logic              in_rng;
  logic              hit;

  assign in_rng = (idx >= ctrl.lo) && (idx <= ctrl.hi);
  assign hit    = (idx == ctrl.sel);

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    priority if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.place && hit) begin
      data_nxt  = ctrl.value;
      valid_nxt = 1'b1;
    end else if (ctrl.up && in_rng) begin
      data_nxt  = lo_data;
      valid_nxt = lo_valid;
    end else if (ctrl.dn && in_rng) begin
      data_nxt  = hi_data;
      valid_nxt = hi_valid;
    end else if (ctrl.kill && hit) begin
      valid_nxt = 1'b0;
    end else begin
      // slot not touched by this command: hold
      data_nxt  = data_r;
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (data_r == ctrl.value);
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;
  assign match_o = match_r;

endmodule

@@ rtl/sle_ctrl.sv @@
// command sequencer: decodes a beat into slot moves and builds the result
module sle_ctrl import sle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_data,
  output logic [IDX_W-1:0]         out_found_index,
  output logic [STAT_W-1:0]        out_status,
  output logic [OLEN_W-1:0]        out_length,
  output logic                     out_is_empty,
  output logic                     out_is_full,
  input  logic [DATA_W-1:0]        slot_data_i [SLOTS],
  input  logic [SLOTS-1:0]         slot_valid_i,
  input  logic [SLOTS-1:0]         match_i,
  output cell_ctrl_t               ctrl_o
);

  `include "shifting_list_engine_top_defines.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIND
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0] first_r, first_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic [IDX_W-1:0]  out_found_r;
  status_t           out_status_r;
  logic [OLEN_W-1:0] out_len_r;
  logic              out_empty_r;
  logic              out_full_r;

  logic              acc;
  logic              out_free;
  logic              ld;
  logic [DATA_W-1:0] res_data;
  logic [IDX_W-1:0]  res_found;
  status_t           res_status;
  cell_ctrl_t        cell_ctrl;

  logic              empty;
  logic              full;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  len_c;
  logic [SLOT_W-1:0] last_slot;
  logic              last_top;
  logic [SLOT_W-1:0] pos_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [DATA_W-1:0] rd_data;
  logic              do_front;
  logic              do_back;

  logic [SLOTS-1:0]  hits;
  logic [SLOTS-1:0]  low_hit;
  logic [SLOT_W-1:0] hit_slot;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign empty     = (len_r == '0);
  assign full      = (len_r == LEN_W'(SLOTS));
  assign pos_c     = CMP_W'(pos_r);
  assign len_c     = CMP_W'(len_r);
  assign last_slot = first_r + SLOT_W'(len_r) - SLOT_W'(1);
  assign last_top  = (last_slot == SLOT_W'(SLOTS - 1));
  assign pos_slot  = first_r + SLOT_W'(pos_r);

  assign do_front = (cmd_r == CMD_INS_FIRST) ||
                    ((cmd_r == CMD_INS_AT) && (empty || (pos_r == '0)));
  assign do_back  = (cmd_r == CMD_INS_LAST) ||
                    ((cmd_r == CMD_INS_AT) && (pos_c == len_c));

  always_comb begin
    unique case (cmd_r)
      CMD_DEL_FIRST: rd_slot = first_r;
      CMD_DEL_LAST:  rd_slot = last_slot;
      default:       rd_slot = pos_slot;
    endcase
  end

  assign rd_data = slot_data_i[rd_slot];

  // first match: isolate the lowest set bit, then encode it
  always_comb begin
    hits     = match_i & slot_valid_i;
    low_hit  = hits & (~hits + {{(SLOTS-1){1'b0}}, 1'b1});
    hit_slot = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (low_hit[k]) begin
        hit_slot = hit_slot | SLOT_W'(k);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    first_nxt       = first_r;
    len_nxt         = len_r;
    ld              = 1'b0;
    res_data        = '0;
    res_found       = '0;
    res_status      = ST_OK;
    cell_ctrl       = '0;
    cell_ctrl.value = val_r;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd_nxt   = cmd_t'(in_cmd);
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if ((cmd_r == CMD_FIND) && !empty) begin
          state_nxt = S_FIND;
        end else if (out_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
          unique case (cmd_r)
            CMD_CLEAR: begin
              cell_ctrl.clr = 1'b1;
              len_nxt       = '0;
              first_nxt     = '0;
            end

            CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
              if ((cmd_r == CMD_INS_AT) && (pos_c > len_c)) begin
                res_status = ST_BAD_POS;
              end else if (full) begin
                res_status = ST_FULL;
              end else begin
                len_nxt         = len_r + LEN_W'(1);
                cell_ctrl.place = 1'b1;
                if (empty) begin
                  cell_ctrl.sel = '0;
                  first_nxt     = '0;
                end else if (do_front) begin
                  if (first_r == '0) begin
                    cell_ctrl.up  = 1'b1;
                    cell_ctrl.lo  = SLOT_W'(1);
                    cell_ctrl.hi  = SLOT_W'(len_r);
                    cell_ctrl.sel = '0;
                  end else begin
                    cell_ctrl.sel = first_r - SLOT_W'(1);
                    first_nxt     = first_r - SLOT_W'(1);
                  end
                end else if (do_back) begin
                  if (!last_top) begin
                    cell_ctrl.sel = last_slot + SLOT_W'(1);
                  end else begin
                    // run touches the top slot: slide it down to make room
                    cell_ctrl.dn  = 1'b1;
                    cell_ctrl.lo  = first_r - SLOT_W'(1);
                    cell_ctrl.hi  = last_slot - SLOT_W'(1);
                    cell_ctrl.sel = last_slot;
                    first_nxt     = first_r - SLOT_W'(1);
                  end
                end else if (!last_top) begin
                  cell_ctrl.up  = 1'b1;
                  cell_ctrl.lo  = pos_slot + SLOT_W'(1);
                  cell_ctrl.hi  = last_slot + SLOT_W'(1);
                  cell_ctrl.sel = pos_slot;
                end else begin
                  cell_ctrl.dn  = 1'b1;
                  cell_ctrl.lo  = first_r - SLOT_W'(1);
                  cell_ctrl.hi  = pos_slot - SLOT_W'(2);
                  cell_ctrl.sel = pos_slot - SLOT_W'(1);
                  first_nxt     = first_r - SLOT_W'(1);
                end
              end
            end

            CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if ((cmd_r == CMD_DEL_AT) && (pos_c >= len_c)) begin
                res_status = ST_BAD_POS;
              end else begin
                res_data       = rd_data;
                len_nxt        = len_r - LEN_W'(1);
                cell_ctrl.kill = 1'b1;
                if (cmd_r == CMD_DEL_FIRST) begin
                  cell_ctrl.sel = first_r;
                  first_nxt     = first_r + SLOT_W'(1);
                end else begin
                  cell_ctrl.sel = last_slot;
                end
                // close the gap: tail moves down by one
                if ((cmd_r == CMD_DEL_AT) && ((pos_c + CMP_W'(1)) < len_c)) begin
                  cell_ctrl.dn = 1'b1;
                  cell_ctrl.lo = pos_slot;
                  cell_ctrl.hi = last_slot - SLOT_W'(1);
                end
                if (len_r == LEN_W'(1)) begin
                  first_nxt = '0;
                end
              end
            end

            CMD_GET, CMD_SET: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (pos_c >= len_c) begin
                res_status = ST_BAD_POS;
              end else if (cmd_r == CMD_GET) begin
                res_data = rd_data;
              end else begin
                cell_ctrl.place = 1'b1;
                cell_ctrl.sel   = pos_slot;
              end
            end

            CMD_FIND: begin
              res_status = ST_EMPTY;
            end

            default: begin
            end
          endcase
        end
      end

      S_FIND: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
          if (|hits) begin
            res_found = IDX_W'(hit_slot - first_r);
          end else begin
            res_status = ST_NOT_FOUND;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ld || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    if (ld) begin
      out_data_r   <= res_data;
      out_found_r  <= res_found;
      out_status_r <= res_status;
      out_len_r    <= OLEN_W'(len_nxt);
      out_empty_r  <= (len_nxt == '0);
      out_full_r   <= (len_nxt == LEN_W'(SLOTS));
    end
  end

  assign ctrl_o          = cell_ctrl;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_found_index = out_found_r;
  assign out_status      = out_status_r;
  assign out_length      = out_len_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;

  `SLE_ASSERT(a_len_matches_slots, $countones(slot_valid_i) == len_r, "length out of step with slots")
  `SLE_ASSERT_IMPL(a_first_occupied, len_r != '0, slot_valid_i[first_r], "first slot not occupied")
  `SLE_ASSERT_IMPL(a_last_occupied, len_r != '0, slot_valid_i[last_slot], "last slot not occupied")
  `SLE_ASSERT_NEXT(a_len_moves_in_exec, state_r != S_EXEC, len_r == $past(len_r), "length moved outside exec")

endmodule

@@ rtl/shifting_list_engine_top.sv @@
// top level of the list engine: command sequencer and the row of slot cells
//
// An ordered list of up to SLOTS 32-bit elements held as one contiguous run
// of occupied slots. One command beat (in_cmd, in_position, in_value) gives
// exactly one result beat (data, found index, status, length, empty, full).
// Both channels move a beat when valid is high and stall is low.
// The result is registered from the exec state once the output is free, or
// for find on a non-empty list from a find state after exec, which covers
// the registered compare in every slot before the first-match encode. The
// sequencer runs one command at a time and takes no new one until the last
// result is loaded. All slot moves of a command happen in the same cycle.
// While a result is stalled at the output, one more command is taken and
// waits until the output register frees up; the stalled result holds.
// Reset is synchronous: the list comes out empty, length zero, no result
// pending. Slot contents are not cleared; only occupied slots are read.
module shifting_list_engine_top import sle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_data,
  output logic [IDX_W-1:0]         out_found_index,
  output logic [STAT_W-1:0]        out_status,
  output logic [OLEN_W-1:0]        out_length,
  output logic                     out_is_empty,
  output logic                     out_is_full
);

  cell_ctrl_t        cell_ctrl;
  logic [DATA_W-1:0] slot_data [SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOTS-1:0]  slot_match;

  sle_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .out_found_index (out_found_index),
    .out_status      (out_status),
    .out_length      (out_length),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .slot_data_i     (slot_data),
    .slot_valid_i    (slot_valid),
    .match_i         (slot_match),
    .ctrl_o          (cell_ctrl)
  );

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    logic [DATA_W-1:0] lo_d;
    logic              lo_v;
    logic [DATA_W-1:0] hi_d;
    logic              hi_v;

    // ends of the row see an empty neighbor
    if (k == 0) begin : g_lo_end
      assign lo_d = '0;
      assign lo_v = 1'b0;
    end else begin : g_lo
      assign lo_d = slot_data[k-1];
      assign lo_v = slot_valid[k-1];
    end

    if (k == SLOTS - 1) begin : g_hi_end
      assign hi_d = '0;
      assign hi_v = 1'b0;
    end else begin : g_hi
      assign hi_d = slot_data[k+1];
      assign hi_v = slot_valid[k+1];
    end

    sle_cell u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (SLOT_W'(k)),
      .ctrl     (cell_ctrl),
      .lo_data  (lo_d),
      .lo_valid (lo_v),
      .hi_data  (hi_d),
      .hi_valid (hi_v),
      .data_o   (slot_data[k]),
      .valid_o  (slot_valid[k]),
      .match_o  (slot_match[k])
    );
  end

endmodule

@@ tb/sv/tb_shifting_list_engine_top.sv @@
// self-checking testbench for the shifting list engine top level
`timescale 1ns / 1ps

module tb_shifting_list_engine_top;
  import sle_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  found_index;
    logic [STAT_W-1:0] status;
    logic [OLEN_W-1:0] length;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY} op_mix_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_cmd = CMD_STATUS;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_data;
  logic [IDX_W-1:0]         out_found_index;
  logic [STAT_W-1:0]        out_status;
  logic [OLEN_W-1:0]        out_length;
  logic                     out_is_empty;
  logic                     out_is_full;

  // shadow copy of the slot array
  logic [DATA_W-1:0] shadow_data [SLOTS];
  logic              shadow_valid [SLOTS];

  list_result_t pending_results[$];
  list_result_t seen_result, due_result;
  int  mismatches = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  shifting_list_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .out_found_index (out_found_index),
    .out_status      (out_status),
    .out_length      (out_length),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void find_run(output int first, output int len);
    bit hit;
    hit = 1'b0;
    first = 0;
    len = 0;
    for (int k = 0; k < SLOTS; k++) begin
      if (shadow_valid[k]) begin
        if (!hit) begin
          first = k;
          hit = 1'b1;
        end
        len++;
      end
    end
  endfunction

  function automatic void occupy_slot(input int k, input logic [DATA_W-1:0] v);
    shadow_data[k] = v;
    shadow_valid[k] = 1'b1;
  endfunction

  // slots a..b move up one, slot a is left free
  function automatic void slide_up(input int a, input int b);
    for (int k = b + 1; k > a; k--) begin
      shadow_data[k] = shadow_data[k-1];
      shadow_valid[k] = shadow_valid[k-1];
    end
    shadow_valid[a] = 1'b0;
  endfunction

  // slots a..b move down one, slot b is left free
  function automatic void slide_down(input int a, input int b);
    for (int k = a; k <= b; k++) begin
      shadow_data[k-1] = shadow_data[k];
      shadow_valid[k-1] = shadow_valid[k];
    end
    shadow_valid[b] = 1'b0;
  endfunction

  function automatic void push_front_elem(input int first, input int len,
                                          input logic [DATA_W-1:0] v);
    if (len == 0) begin
      occupy_slot(0, v);
    end else if (first == 0) begin
      slide_up(0, len - 1);
      occupy_slot(0, v);
    end else begin
      occupy_slot(first - 1, v);
    end
  endfunction

  function automatic void push_back_elem(input int first, input int len,
                                         input logic [DATA_W-1:0] v);
    int last;
    last = first + len - 1;
    if (len == 0) begin
      occupy_slot(0, v);
    end else if (last != SLOTS - 1) begin
      occupy_slot(last + 1, v);
    end else begin
      slide_down(first, last);
      occupy_slot(SLOTS - 1, v);
    end
  endfunction

  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] c,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] v);
    list_result_t r;
    int first, len, last, p;
    bit hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    find_run(first, len);
    last = first + len - 1;
    p = pos;
    case (c)
      CMD_CLEAR: begin
        foreach (shadow_valid[k]) shadow_valid[k] = 1'b0;
      end
      CMD_INS_FIRST: begin
        if (len == SLOTS) r.status = ST_FULL;
        else push_front_elem(first, len, v);
      end
      CMD_INS_LAST: begin
        if (len == SLOTS) r.status = ST_FULL;
        else push_back_elem(first, len, v);
      end
      CMD_INS_AT: begin
        // position is checked before fullness
        if (p > len) r.status = ST_BAD_POS;
        else if (len == SLOTS) r.status = ST_FULL;
        else if (len == 0 || p == 0) push_front_elem(first, len, v);
        else if (p == len) push_back_elem(first, len, v);
        else if (last != SLOTS - 1) begin
          slide_up(first + p, last);
          occupy_slot(first + p, v);
        end else begin
          slide_down(first, first + p - 1);
          occupy_slot(first + p - 1, v);
        end
      end
      CMD_DEL_FIRST: begin
        if (len == 0) r.status = ST_EMPTY;
        else begin
          r.data = shadow_data[first];
          shadow_valid[first] = 1'b0;
        end
      end
      CMD_DEL_LAST: begin
        if (len == 0) r.status = ST_EMPTY;
        else begin
          r.data = shadow_data[last];
          shadow_valid[last] = 1'b0;
        end
      end
      CMD_DEL_AT: begin
        if (len == 0) r.status = ST_EMPTY;
        else if (p >= len) r.status = ST_BAD_POS;
        else begin
          r.data = shadow_data[first + p];
          if (p + 1 < len) slide_down(first + p + 1, last);
          else shadow_valid[last] = 1'b0;
        end
      end
      CMD_GET: begin
        if (len == 0) r.status = ST_EMPTY;
        else if (p >= len) r.status = ST_BAD_POS;
        else r.data = shadow_data[first + p];
      end
      CMD_SET: begin
        if (len == 0) r.status = ST_EMPTY;
        else if (p >= len) r.status = ST_BAD_POS;
        else shadow_data[first + p] = v;
      end
      CMD_FIND: begin
        if (len == 0) r.status = ST_EMPTY;
        else begin
          r.status = ST_NOT_FOUND;
          for (int k = 0; k < len; k++) begin
            if (!hit && shadow_data[first + k] == v) begin
              r.found_index = IDX_W'(k);
              r.status = ST_OK;
              hit = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    find_run(first, len);
    r.length = OLEN_W'(len);
    r.is_empty = (len == 0);
    r.is_full = (len == SLOTS);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '0;
        default: return '1;
      endcase
    end
    // small values make duplicates so find has to pick the first match
    if (roll < 35) return DATA_W'($urandom_range(0, 3));
    return $urandom;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                          input logic [DATA_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_cmd <= c;
    in_position <= p;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_cmd(c, p, v));
    items_sent++;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // random result-side stalls, bursty
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (!calm && rst_n && $urandom_range(0, 2) == 0) stall_left = gap_len();
    out_stall <= (stall_left > 0);
  end

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(input string what, input list_result_t want,
                               input list_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s): want data %h idx %0d st %0d len %0d e %b f %b",
               what, want.data, want.found_index, want.status, want.length,
               want.is_empty, want.is_full);
      $display("               got  data %h idx %0d st %0d len %0d e %b f %b",
               got.data, got.found_index, got.status, got.length,
               got.is_empty, got.is_full);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result = '{out_data, out_found_index, out_status, out_length,
                      out_is_empty, out_is_full};
      if (pending_results.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, seen_result);
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.data !== due_result.data ||
            seen_result.found_index !== due_result.found_index ||
            seen_result.status !== due_result.status ||
            seen_result.length !== due_result.length ||
            seen_result.is_empty !== due_result.is_empty ||
            seen_result.is_full !== due_result.is_full)
          note_mismatch("field", due_result, seen_result);
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_list();
    send_cmd(CMD_DEL_FIRST, '0, '0);
    send_cmd(CMD_DEL_LAST, '0, '0);
    send_cmd(CMD_GET, '0, '0);
    send_cmd(CMD_SET, '0, 32'h1234_5678);
    send_cmd(CMD_FIND, '0, '0);
    send_cmd(CMD_INS_AT, POS_W'(1), 32'h0bad_0bad);
    // first element of an empty list lands in slot 0
    send_cmd(CMD_INS_AT, '0, 32'h7fff_ffff);
  endtask

  task automatic test_full_list();
    for (int k = 1; k < SLOTS; k++) begin
      case (k % 3)
        0: send_cmd(CMD_INS_FIRST, '0, 32'h8000_0000 + k);
        1: send_cmd(CMD_INS_LAST, '0, 32'hffff_ff00 + k);
        default: send_cmd(CMD_INS_AT, POS_W'(k / 2), 32'h5555_aaaa ^ k);
      endcase
    end
    // bad position wins over full
    send_cmd(CMD_INS_AT, POS_W'(SLOTS + 1), '0);
    send_cmd(CMD_INS_FIRST, '0, '1);
    send_cmd(CMD_SPARE_HI, '1, '1);
    send_cmd(CMD_CLEAR, '0, '0);
  endtask

  task automatic issue_random_op(input op_mix_t mix);
    int first, len, roll;
    logic [CMD_W-1:0]  c;
    logic [POS_W-1:0]  p;
    logic [DATA_W-1:0] v;
    find_run(first, len);
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      // raw noise over every code and position
      send_cmd(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)),
               POS_W'($urandom_range(0, (1 << POS_W) - 1)), $urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (mix == MIX_GROW && roll < 75)
        c = cmd_t'($urandom_range(CMD_INS_FIRST, CMD_INS_AT));
      else if (mix == MIX_SHRINK && roll < 75)
        c = cmd_t'($urandom_range(CMD_DEL_FIRST, CMD_DEL_AT));
      else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) c = CMD_CLEAR;
        else if (roll < 8) c = CMD_STATUS;
        else c = cmd_t'($urandom_range(CMD_INS_FIRST, CMD_FIND));
      end
      if ($urandom_range(0, 99) < 8) p = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      else if (c == CMD_INS_AT) p = POS_W'($urandom_range(0, len));
      else if (len > 0) p = POS_W'($urandom_range(0, len - 1));
      else p = '0;
      if (c == CMD_FIND && len > 0 && $urandom_range(0, 3) != 0)
        v = shadow_data[first + $urandom_range(0, len - 1)];
      else
        v = pick_value();
      send_cmd(c, p, v);
    end
  endtask

  task automatic test_random_traffic(input int budget);
    int goal, episode, n;
    op_mix_t mix;
    goal = items_sent + budget;
    episode = 0;
    while (items_sent < goal) begin
      mix = op_mix_t'($urandom_range(MIX_GROW, MIX_ANY));
      n = $urandom_range(4, 30);
      calm = (episode % 9 == 4);
      repeat (n) issue_random_op(mix);
      // hold the sender off until the engine has caught up
      if (episode % 25 == 12) drain_results();
      episode++;
    end
    calm = 1'b0;
  endtask

  initial begin
    foreach (shadow_valid[k]) begin
      shadow_valid[k] = 1'b0;
      shadow_data[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_full_list();
    test_random_traffic(1680);
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
